[rtl/mmc3_pkg.sv]
// shared types and constants for the mmc3 chr ram bank mapper
`timescale 1ns / 1ps
`default_nettype none

package mmc3_pkg;

    typedef struct packed {
        logic        mode;
        logic [15:0] address;
        logic [7:0]  data;
        logic [8:0]  scanline;
        logic        rendering_on;
    } t_req;

    typedef struct packed {
        logic [31:0] prg_map;
        logic [31:0] chr_map_low;
        logic [31:0] chr_map_high;
        logic [7:0]  chr_ram_slots;
        logic [1:0]  mirror_mode;
        logic        irq_pulse;
    } t_res;

    localparam logic       MODE_WRITE = 1'b0;
    localparam logic       MODE_TICK  = 1'b1;

    localparam logic [15:0] ADDR_MASK     = 16'hE001;
    localparam logic [15:0] ADDR_COMMAND  = 16'h8000;
    localparam logic [15:0] ADDR_BANK     = 16'h8001;
    localparam logic [15:0] ADDR_MIRROR   = 16'hA000;
    localparam logic [15:0] ADDR_PROTECT  = 16'hA001;
    localparam logic [15:0] ADDR_IRQ_CNT  = 16'hC000;
    localparam logic [15:0] ADDR_IRQ_LAT  = 16'hC001;
    localparam logic [15:0] ADDR_IRQ_OFF  = 16'hE000;
    localparam logic [15:0] ADDR_IRQ_ON   = 16'hE001;

    localparam logic [2:0] SEL_CHR_0 = 3'd0;
    localparam logic [2:0] SEL_CHR_1 = 3'd1;
    localparam logic [2:0] SEL_CHR_2 = 3'd2;
    localparam logic [2:0] SEL_CHR_3 = 3'd3;
    localparam logic [2:0] SEL_CHR_4 = 3'd4;
    localparam logic [2:0] SEL_CHR_5 = 3'd5;
    localparam logic [2:0] SEL_PRG_0 = 3'd6;
    localparam logic [2:0] SEL_PRG_1 = 3'd7;

    localparam int CMD_PRG_SWAP_BIT = 6;
    localparam int CMD_CHR_SWAP_BIT = 7;
    localparam int CHR_RAM_BIT      = 6;

    localparam logic [7:0] EVEN_BANK_MASK    = 8'hFE;
    localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;

    localparam logic [1:0] MIRROR_VERT  = 2'd0;
    localparam logic [1:0] MIRROR_HORIZ = 2'd1;
    localparam logic [1:0] MIRROR_FOUR  = 2'd2;

    localparam logic [1:0] REG_HAS_CHR_ROM    = 2'd0;
    localparam logic [1:0] REG_PRG_BANK_COUNT = 2'd1;
    localparam logic [1:0] REG_FOUR_SCREEN    = 2'd2;

endpackage

`default_nettype wire

[rtl/mmc3_chr_ram_bank_mapper.sv]
// top level of the mmc3 chr ram bank mapper with chr ram paging
//
// requests enter on i_in_valid / o_in_stall with payload i_in_req: either a
// cpu register write (mode 0, address and data) or a scanline tick (mode 1,
// scanline and rendering_on). every request yields one result on
// o_out_valid / i_out_stall with payload o_out_res: the bank map after the
// request plus the irq pulse of a tick.
// the bank state and the result register load at the edge that accepts the
// request. one request per cycle is sustained while the receiver does not stall;
// the single result register sets that figure and lets a new request in at the
// same edge its old result is taken.
// when the receiver stalls with a result pending, o_in_stall rises and the
// result holds until taken.
// the apb port reads and writes has_chr_rom (0x0), prg_bank_count (0x4) and
// four_screen (0x8); write it only while no request is in flight.
// synchronous reset restores the power-on bank map and configuration and
// empties the result register.
`timescale 1ns / 1ps
`default_nettype none

module mmc3_chr_ram_bank_mapper (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire mmc3_pkg::t_req    i_in_req,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output mmc3_pkg::t_res         o_out_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic       r_has_chr_rom;
    logic [8:0] r_prg_bank_count;
    logic       r_four_screen;

    logic [7:0] r_command;
    logic [7:0] r_chr_banks [6];
    logic [7:0] r_prg_banks [2];
    logic [7:0] r_irq_count;
    logic [7:0] r_irq_reload;
    logic       r_irq_on;
    logic       r_mirror_horiz;

    logic [7:0] n_command;
    logic [7:0] n_chr_banks [6];
    logic [7:0] n_prg_banks [2];
    logic [7:0] n_irq_count;
    logic [7:0] n_irq_reload;
    logic       n_irq_on;
    logic       n_mirror_horiz;
    logic       n_pulse;

    logic           r_out_valid;
    mmc3_pkg::t_res r_out_res;
    mmc3_pkg::t_res n_out_res;

    logic       in_acc;
    logic       cfg_wr;
    logic [1:0] cfg_idx;
    logic [2:0] bank_sel;
    logic [7:0] second_last;
    logic [7:0] last;
    logic [7:0] pairs [4];
    logic [7:0] singles [4];
    logic [7:0] slots [8];

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_acc      = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[3:2];

    always_comb begin
        prdata = 32'd0;
        unique case (cfg_idx)
            mmc3_pkg::REG_HAS_CHR_ROM:    prdata = {31'd0, r_has_chr_rom};
            mmc3_pkg::REG_PRG_BANK_COUNT: prdata = {23'd0, r_prg_bank_count};
            mmc3_pkg::REG_FOUR_SCREEN:    prdata = {31'd0, r_four_screen};
            default:                      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_chr_rom    <= 1'b1;
            r_prg_bank_count <= 9'd16;
            r_four_screen    <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                mmc3_pkg::REG_HAS_CHR_ROM:    r_has_chr_rom    <= pwdata[0];
                mmc3_pkg::REG_PRG_BANK_COUNT: r_prg_bank_count <= pwdata[8:0];
                mmc3_pkg::REG_FOUR_SCREEN:    r_four_screen    <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register writes and scanline counter
    assign bank_sel = r_command[2:0];

    always_comb begin
        n_command      = r_command;
        n_chr_banks    = r_chr_banks;
        n_prg_banks    = r_prg_banks;
        n_irq_count    = r_irq_count;
        n_irq_reload   = r_irq_reload;
        n_irq_on       = r_irq_on;
        n_mirror_horiz = r_mirror_horiz;
        n_pulse        = 1'b0;
        if (i_in_req.mode == mmc3_pkg::MODE_WRITE) begin
            unique case (i_in_req.address & mmc3_pkg::ADDR_MASK)
                mmc3_pkg::ADDR_COMMAND: n_command = i_in_req.data;
                mmc3_pkg::ADDR_BANK: begin
                    unique case (bank_sel)
                        mmc3_pkg::SEL_CHR_0: if (r_has_chr_rom) begin
                            n_chr_banks[0] = i_in_req.data & mmc3_pkg::EVEN_BANK_MASK;
                        end
                        mmc3_pkg::SEL_CHR_1: if (r_has_chr_rom) begin
                            n_chr_banks[1] = i_in_req.data & mmc3_pkg::EVEN_BANK_MASK;
                        end
                        mmc3_pkg::SEL_CHR_2: if (r_has_chr_rom) begin
                            n_chr_banks[2] = i_in_req.data;
                        end
                        mmc3_pkg::SEL_CHR_3: if (r_has_chr_rom) begin
                            n_chr_banks[3] = i_in_req.data;
                        end
                        mmc3_pkg::SEL_CHR_4: if (r_has_chr_rom) begin
                            n_chr_banks[4] = i_in_req.data;
                        end
                        mmc3_pkg::SEL_CHR_5: if (r_has_chr_rom) begin
                            n_chr_banks[5] = i_in_req.data;
                        end
                        mmc3_pkg::SEL_PRG_0: n_prg_banks[0] = i_in_req.data;
                        mmc3_pkg::SEL_PRG_1: n_prg_banks[1] = i_in_req.data;
                        default: ;
                    endcase
                end
                mmc3_pkg::ADDR_MIRROR: begin
                    if (!r_four_screen) begin
                        n_mirror_horiz = i_in_req.data[0];
                    end
                end
                mmc3_pkg::ADDR_PROTECT: ;
                mmc3_pkg::ADDR_IRQ_CNT: n_irq_count  = i_in_req.data;
                mmc3_pkg::ADDR_IRQ_LAT: n_irq_reload = i_in_req.data;
                mmc3_pkg::ADDR_IRQ_OFF: n_irq_on     = 1'b0;
                mmc3_pkg::ADDR_IRQ_ON:  n_irq_on     = 1'b1;
                default: ;
            endcase
        end else if (r_irq_on && i_in_req.rendering_on
                     && i_in_req.scanline <= mmc3_pkg::LAST_VISIBLE_LINE) begin
            if (r_irq_count == 8'd0) begin
                n_irq_count = r_irq_reload;
                n_pulse     = 1'b1;
            end else begin
                n_irq_count = r_irq_count - 8'd1;
            end
        end
    end

    // bank map from the updated state
    assign second_last = r_prg_bank_count[7:0] - 8'd2;
    assign last        = r_prg_bank_count[7:0] - 8'd1;

    always_comb begin
        pairs[0] = n_chr_banks[0];
        pairs[1] = n_chr_banks[0] + 8'd1;
        pairs[2] = n_chr_banks[1];
        pairs[3] = n_chr_banks[1] + 8'd1;
        for (int i = 0; i < 4; i++) begin
            singles[i] = n_chr_banks[2 + i];
            if (n_command[mmc3_pkg::CMD_CHR_SWAP_BIT]) begin
                slots[i]     = singles[i];
                slots[4 + i] = pairs[i];
            end else begin
                slots[i]     = pairs[i];
                slots[4 + i] = singles[i];
            end
        end
        if (n_command[mmc3_pkg::CMD_PRG_SWAP_BIT]) begin
            n_out_res.prg_map = {last, n_prg_banks[0], n_prg_banks[1], second_last};
        end else begin
            n_out_res.prg_map = {last, second_last, n_prg_banks[1], n_prg_banks[0]};
        end
        n_out_res.chr_map_low  = {slots[3], slots[2], slots[1], slots[0]};
        n_out_res.chr_map_high = {slots[7], slots[6], slots[5], slots[4]};
        for (int i = 0; i < 8; i++) begin
            n_out_res.chr_ram_slots[i] = slots[i][mmc3_pkg::CHR_RAM_BIT];
        end
        if (r_four_screen) begin
            n_out_res.mirror_mode = mmc3_pkg::MIRROR_FOUR;
        end else if (n_mirror_horiz) begin
            n_out_res.mirror_mode = mmc3_pkg::MIRROR_HORIZ;
        end else begin
            n_out_res.mirror_mode = mmc3_pkg::MIRROR_VERT;
        end
        n_out_res.irq_pulse = n_pulse;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_command      <= 8'd0;
            r_chr_banks[0] <= 8'd0;
            r_chr_banks[1] <= 8'd2;
            r_chr_banks[2] <= 8'd4;
            r_chr_banks[3] <= 8'd5;
            r_chr_banks[4] <= 8'd6;
            r_chr_banks[5] <= 8'd7;
            r_prg_banks[0] <= 8'd0;
            r_prg_banks[1] <= 8'd1;
            r_irq_count    <= 8'd0;
            r_irq_reload   <= 8'd0;
            r_irq_on       <= 1'b0;
            r_mirror_horiz <= 1'b0;
        end else if (in_acc) begin
            r_command      <= n_command;
            r_chr_banks    <= n_chr_banks;
            r_prg_banks    <= n_prg_banks;
            r_irq_count    <= n_irq_count;
            r_irq_reload   <= n_irq_reload;
            r_irq_on       <= n_irq_on;
            r_mirror_horiz <= n_mirror_horiz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_res <= n_out_res;
        end
    end

`ifndef SYNTHESIS
    a_pulse_reloads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && n_pulse |=> r_irq_count == $past(r_irq_reload))
        else $error("irq pulse without counter reload");

    a_pulse_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_req.mode == mmc3_pkg::MODE_WRITE |=> !r_out_res.irq_pulse)
        else $error("irq pulse on a cpu write");

    a_pair_banks_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_chr_banks[0][0] && !r_chr_banks[1][0])
        else $error("chr pair bank has bit 0 set");

    a_irq_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_req.mode == mmc3_pkg::MODE_WRITE
        && (i_in_req.address & mmc3_pkg::ADDR_MASK) == mmc3_pkg::ADDR_IRQ_OFF
        |=> !r_irq_on)
        else $error("irq still enabled after disable write");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_stall && !in_acc |=> !r_out_valid)
        else $error("result not released after being taken");
`endif

endmodule

`default_nettype wire
